// File: hdl/btas_pkg.sv
package btas_pkg;

    // Register count of the core, bit 15 (PC) is always honored
    localparam int BTAS_NUM_REGS = 16;
    localparam int NUM_MASK_BITS = 16;

    localparam int ADDR_W      = 32;
    localparam int REG_IDX_W   = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int PC_OFFS_W   = 4;
    localparam int COUNT_W     = 5;

    localparam logic [REG_IDX_W-1:0] PC_INDEX   = 4'd15;
    localparam logic [ADDR_W-1:0]    WORD_BYTES = 32'd4;
    localparam logic [ADDR_W-1:0]    WORD_MASK  = 32'hFFFF_FFFC;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_XFER   = 2'd0,
        KIND_UNDEF  = 2'd1,
        KIND_ALIGN  = 2'd2,
        KIND_FINISH = 2'd3
    } t_kind;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARCH_V7       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARCH_V6       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNALIGNED_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_CHECK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RESTORED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PC_STORE_OFFS = 3'd5;

    localparam logic [PC_OFFS_W-1:0] PC_STORE_OFFS_RST = 4'd8;

    // Configuration state handed to the sequencer
    typedef struct packed {
        logic                 arch_v7;
        logic                 arch_v6;
        logic                 unaligned_en;
        logic                 align_check;
        logic                 base_restored;
        logic [PC_OFFS_W-1:0] pc_store_offs;
    } t_cfg;

endpackage

// File: hdl/block_transfer_address_sequencer_top.sv
// Address sequencer for one load/store-multiple instruction.
// Input channel: one request per instruction (register mask, base register
// and value, instruction address, L/W/P/U/S bits), taken when i_in_valid is
// high and o_in_stall is low. o_in_stall stays high while an instruction is
// in work. Output channel: results on o_out_valid, taken when i_out_stall is
// low; the last result of an instruction has o_last set.
// Results: one undefined result, or one alignment-fault result, or one
// transfer per listed register in ascending order (a load that lists its
// base register moves that transfer to the end) followed by a finish result.
// Timing: one shared 32-bit adder computes the new base, the start address,
// the stored PC value and then each transfer address, one per cycle while the
// output is not stalled. The next request can be taken in the cycle after the
// last result is loaded into the output register, before that result is taken.
// A stalled output holds its result and the sequencer waits behind it.
// Configuration writes on i_cfg_we land at once; write only while idle.
// Reset (synchronous, active low) returns to idle, drops any pending result
// and loads the configuration reset values.
module block_transfer_address_sequencer_top #(
    parameter int NUM_REGS = btas_pkg::BTAS_NUM_REGS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [btas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [15:0]                     i_register_mask,
    input  logic [3:0]                      i_base_reg,
    input  logic [31:0]                     i_base_value,
    input  logic [31:0]                     i_instr_address,
    input  logic                            i_is_load_insn,
    input  logic                            i_writeback_bit,
    input  logic                            i_pre_index_bit,
    input  logic                            i_up_bit,
    input  logic                            i_s_bit,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_kind,
    output logic [3:0]                      o_reg_index,
    output logic [31:0]                     o_address,
    output logic                            o_is_load,
    output logic                            o_user_bank,
    output logic [31:0]                     o_pc_store_value,
    output logic                            o_write_base,
    output logic [31:0]                     o_new_base,
    output logic                            o_exception_return,
    output logic                            o_pc_written,
    output logic                            o_last
);
    import btas_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b0_0000_0001,
        ST_NBASE  = 9'b0_0000_0010,
        ST_START  = 9'b0_0000_0100,
        ST_PCSV   = 9'b0_0000_1000,
        ST_XFER   = 9'b0_0001_0000,
        ST_DEFER  = 9'b0_0010_0000,
        ST_FINISH = 9'b0_0100_0000,
        ST_UNDEF  = 9'b0_1000_0000,
        ST_FAULT  = 9'b1_0000_0000
    } t_state;

    // Mask bits that exist on this core: low NUM_REGS registers plus PC
    localparam logic [NUM_MASK_BITS-1:0] KEEP_MASK =
        NUM_MASK_BITS'((32'd1 << NUM_REGS) - 32'd1) |
        (NUM_MASK_BITS'(1) << PC_INDEX);

    t_cfg cfg;

    btas_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Control and instruction registers
    t_state                     r_state, n_state;
    logic [NUM_MASK_BITS-1:0]   r_list, n_list;
    logic [NUM_MASK_BITS-1:0]   r_rem, n_rem;
    logic [REG_IDX_W-1:0]       r_rn, n_rn;
    logic [ADDR_W-1:0]          r_base, n_base;
    logic [ADDR_W-1:0]          r_iaddr, n_iaddr;
    logic                       r_load, n_load;
    logic                       r_wback, n_wback;
    logic                       r_pre, n_pre;
    logic                       r_up, n_up;
    logic                       r_sbit, n_sbit;
    logic [ADDR_W-1:0]          r_nbase, n_nbase;
    logic [ADDR_W-1:0]          r_cur, n_cur;
    logic [ADDR_W-1:0]          r_pcsv, n_pcsv;
    logic [ADDR_W-1:0]          r_defer_addr, n_defer_addr;

    // Output register
    logic                       r_o_valid, n_o_valid;
    t_kind                      r_o_kind, n_o_kind;
    logic [REG_IDX_W-1:0]       r_o_reg_index, n_o_reg_index;
    logic [ADDR_W-1:0]          r_o_address, n_o_address;
    logic                       r_o_is_load, n_o_is_load;
    logic                       r_o_user_bank, n_o_user_bank;
    logic [ADDR_W-1:0]          r_o_pc_store_value, n_o_pc_store_value;
    logic                       r_o_write_base, n_o_write_base;
    logic [ADDR_W-1:0]          r_o_new_base, n_o_new_base;
    logic                       r_o_exception_return, n_o_exception_return;
    logic                       r_o_pc_written, n_o_pc_written;
    logic                       r_o_last, n_o_last;

    // Decode of the incoming request for the undefined check
    logic [NUM_MASK_BITS-1:0]   in_list;
    logic                       in_rn_in;
    logic                       in_exc;
    logic                       in_user;
    logic                       in_undef;
    logic                       in_accept;

    always_comb begin
        in_list  = i_register_mask & KEEP_MASK;
        in_rn_in = in_list[i_base_reg];
        in_exc   = i_s_bit && i_is_load_insn && in_list[PC_INDEX];
        in_user  = i_s_bit && !in_exc;
        in_undef = (i_base_reg == PC_INDEX) || (in_list == '0) ||
                   (i_is_load_insn && i_writeback_bit && in_rn_in && cfg.arch_v7) ||
                   (in_user && i_writeback_bit);
        in_accept = i_in_valid && (r_state == ST_IDLE);
    end

    // Flags of the held instruction
    logic                       rn_in;
    logic                       pc_in;
    logic                       exc;
    logic                       user;
    logic                       do_wb;
    logic                       defer;
    logic                       ignore_align;
    logic [COUNT_W-1:0]         count;
    logic [ADDR_W-1:0]          span;

    always_comb begin
        rn_in        = r_list[r_rn];
        pc_in        = r_list[PC_INDEX];
        exc          = r_sbit && r_load && pc_in;
        user         = r_sbit && !exc;
        do_wb        = r_wback && !(r_load && rn_in);
        defer        = r_load && rn_in;
        ignore_align = !(cfg.arch_v7 || (cfg.arch_v6 && cfg.unaligned_en)) &&
                       !cfg.align_check;
        count = '0;
        for (int i = 0; i < NUM_MASK_BITS; i++) begin
            count = count + COUNT_W'(r_list[i]);
        end
        span = ADDR_W'(count) << 2;
    end

    // Lowest remaining register in the list
    logic [REG_IDX_W-1:0]       next_idx;
    logic [NUM_MASK_BITS-1:0]   rem_cleared;

    always_comb begin
        next_idx = '0;
        for (int i = NUM_MASK_BITS - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                next_idx = REG_IDX_W'(i);
            end
        end
        rem_cleared = r_rem & (r_rem - NUM_MASK_BITS'(1));
    end

    // Operand select for the shared adder
    logic [ADDR_W-1:0] alu_a;
    logic [ADDR_W-1:0] alu_b;
    logic              alu_sub;
    logic [ADDR_W-1:0] alu_sum;

    always_comb begin
        alu_a   = r_cur;
        alu_b   = WORD_BYTES;
        alu_sub = 1'b0;
        unique case (r_state)
            ST_NBASE: begin
                alu_a   = r_base;
                alu_b   = span;
                alu_sub = !r_up;
            end
            ST_START: begin
                alu_a = r_up ? r_base : r_nbase;
                alu_b = (r_pre == r_up) ? WORD_BYTES : '0;
            end
            ST_PCSV: begin
                alu_a = r_iaddr;
                alu_b = ADDR_W'(cfg.pc_store_offs);
            end
            default: begin
                alu_a   = r_cur;
                alu_b   = WORD_BYTES;
                alu_sub = 1'b0;
            end
        endcase
    end

    btas_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    logic can_emit;
    assign can_emit = !r_o_valid || !i_out_stall;

    // Sequencer and result formation
    always_comb begin
        n_state      = r_state;
        n_list       = r_list;
        n_rem        = r_rem;
        n_rn         = r_rn;
        n_base       = r_base;
        n_iaddr      = r_iaddr;
        n_load       = r_load;
        n_wback      = r_wback;
        n_pre        = r_pre;
        n_up         = r_up;
        n_sbit       = r_sbit;
        n_nbase      = r_nbase;
        n_cur        = r_cur;
        n_pcsv       = r_pcsv;
        n_defer_addr = r_defer_addr;

        // output register drains when taken
        n_o_valid            = r_o_valid && i_out_stall;
        n_o_kind             = r_o_kind;
        n_o_reg_index        = r_o_reg_index;
        n_o_address          = r_o_address;
        n_o_is_load          = r_o_is_load;
        n_o_user_bank        = r_o_user_bank;
        n_o_pc_store_value   = r_o_pc_store_value;
        n_o_write_base       = r_o_write_base;
        n_o_new_base         = r_o_new_base;
        n_o_exception_return = r_o_exception_return;
        n_o_pc_written       = r_o_pc_written;
        n_o_last             = r_o_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_list  = in_list;
                    n_rem   = in_list;
                    n_rn    = i_base_reg;
                    n_base  = i_base_value;
                    n_iaddr = i_instr_address;
                    n_load  = i_is_load_insn;
                    n_wback = i_writeback_bit;
                    n_pre   = i_pre_index_bit;
                    n_up    = i_up_bit;
                    n_sbit  = i_s_bit;
                    n_state = in_undef ? ST_UNDEF : ST_NBASE;
                end
            end
            ST_NBASE: begin
                n_nbase = alu_sum;
                n_state = ST_START;
            end
            ST_START: begin
                if (ignore_align) begin
                    n_cur   = alu_sum & WORD_MASK;
                    n_state = ST_PCSV;
                end else if (alu_sum[1:0] != 2'b00) begin
                    n_cur   = alu_sum;
                    n_state = ST_FAULT;
                end else begin
                    n_cur   = alu_sum;
                    n_state = ST_PCSV;
                end
            end
            ST_PCSV: begin
                n_pcsv  = alu_sum;
                n_state = ST_XFER;
            end
            ST_XFER: begin
                if (defer && (next_idx == r_rn)) begin
                    // base register load goes last
                    n_defer_addr = r_cur;
                    n_cur        = alu_sum;
                    n_rem        = rem_cleared;
                end else if (can_emit) begin
                    n_o_valid            = 1'b1;
                    n_o_kind             = KIND_XFER;
                    n_o_reg_index        = next_idx;
                    n_o_address          = r_cur;
                    n_o_is_load          = r_load;
                    n_o_user_bank        = user && (next_idx != PC_INDEX);
                    n_o_pc_store_value   = (!r_load && (next_idx == PC_INDEX)) ?
                                           r_pcsv : '0;
                    n_o_write_base       = 1'b0;
                    n_o_new_base         = '0;
                    n_o_exception_return = 1'b0;
                    n_o_pc_written       = 1'b0;
                    n_o_last             = 1'b0;
                    n_cur                = alu_sum;
                    n_rem                = rem_cleared;
                end
                if (n_rem == '0) begin
                    n_state = defer ? ST_DEFER : ST_FINISH;
                end
            end
            ST_DEFER: begin
                if (can_emit) begin
                    n_o_valid            = 1'b1;
                    n_o_kind             = KIND_XFER;
                    n_o_reg_index        = r_rn;
                    n_o_address          = r_defer_addr;
                    n_o_is_load          = 1'b1;
                    n_o_user_bank        = user;
                    n_o_pc_store_value   = '0;
                    n_o_write_base       = 1'b0;
                    n_o_new_base         = '0;
                    n_o_exception_return = 1'b0;
                    n_o_pc_written       = 1'b0;
                    n_o_last             = 1'b0;
                    n_state              = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (can_emit) begin
                    n_o_valid            = 1'b1;
                    n_o_kind             = KIND_FINISH;
                    n_o_reg_index        = '0;
                    n_o_address          = '0;
                    n_o_is_load          = 1'b0;
                    n_o_user_bank        = 1'b0;
                    n_o_pc_store_value   = '0;
                    n_o_write_base       = do_wb;
                    n_o_new_base         = r_nbase;
                    n_o_exception_return = exc;
                    n_o_pc_written       = r_load && pc_in;
                    n_o_last             = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            ST_UNDEF: begin
                if (can_emit) begin
                    n_o_valid            = 1'b1;
                    n_o_kind             = KIND_UNDEF;
                    n_o_reg_index        = '0;
                    n_o_address          = '0;
                    n_o_is_load          = 1'b0;
                    n_o_user_bank        = 1'b0;
                    n_o_pc_store_value   = '0;
                    n_o_write_base       = 1'b0;
                    n_o_new_base         = '0;
                    n_o_exception_return = 1'b0;
                    n_o_pc_written       = 1'b0;
                    n_o_last             = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            ST_FAULT: begin
                if (can_emit) begin
                    n_o_valid            = 1'b1;
                    n_o_kind             = KIND_ALIGN;
                    n_o_reg_index        = '0;
                    n_o_address          = r_cur;
                    n_o_is_load          = 1'b0;
                    n_o_user_bank        = 1'b0;
                    n_o_pc_store_value   = '0;
                    n_o_write_base       = do_wb && !cfg.base_restored;
                    n_o_new_base         = r_nbase;
                    n_o_exception_return = 1'b0;
                    n_o_pc_written       = 1'b0;
                    n_o_last             = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_list               <= n_list;
        r_rem                <= n_rem;
        r_rn                 <= n_rn;
        r_base               <= n_base;
        r_iaddr              <= n_iaddr;
        r_load               <= n_load;
        r_wback              <= n_wback;
        r_pre                <= n_pre;
        r_up                 <= n_up;
        r_sbit               <= n_sbit;
        r_nbase              <= n_nbase;
        r_cur                <= n_cur;
        r_pcsv               <= n_pcsv;
        r_defer_addr         <= n_defer_addr;
        r_o_kind             <= n_o_kind;
        r_o_reg_index        <= n_o_reg_index;
        r_o_address          <= n_o_address;
        r_o_is_load          <= n_o_is_load;
        r_o_user_bank        <= n_o_user_bank;
        r_o_pc_store_value   <= n_o_pc_store_value;
        r_o_write_base       <= n_o_write_base;
        r_o_new_base         <= n_o_new_base;
        r_o_exception_return <= n_o_exception_return;
        r_o_pc_written       <= n_o_pc_written;
        r_o_last             <= n_o_last;
    end

    assign o_in_stall         = (r_state != ST_IDLE);
    assign o_out_valid        = r_o_valid;
    assign o_kind             = r_o_kind;
    assign o_reg_index        = r_o_reg_index;
    assign o_address          = r_o_address;
    assign o_is_load          = r_o_is_load;
    assign o_user_bank        = r_o_user_bank;
    assign o_pc_store_value   = r_o_pc_store_value;
    assign o_write_base       = r_o_write_base;
    assign o_new_base         = r_o_new_base;
    assign o_exception_return = r_o_exception_return;
    assign o_pc_written       = r_o_pc_written;
    assign o_last             = r_o_last;

endmodule

// File: hdl/btas_cfg.sv
module btas_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [btas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output btas_pkg::t_cfg                  o_cfg
);
    import btas_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register write decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ARCH_V7:       n_cfg.arch_v7       = i_cfg_data[0];
                CFG_ARCH_V6:       n_cfg.arch_v6       = i_cfg_data[0];
                CFG_UNALIGNED_EN:  n_cfg.unaligned_en  = i_cfg_data[0];
                CFG_ALIGN_CHECK:   n_cfg.align_check   = i_cfg_data[0];
                CFG_BASE_RESTORED: n_cfg.base_restored = i_cfg_data[0];
                CFG_PC_STORE_OFFS: n_cfg.pc_store_offs = i_cfg_data[PC_OFFS_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arch_v7       <= 1'b1;
            r_cfg.arch_v6       <= 1'b0;
            r_cfg.unaligned_en  <= 1'b0;
            r_cfg.align_check   <= 1'b0;
            r_cfg.base_restored <= 1'b0;
            r_cfg.pc_store_offs <= PC_STORE_OFFS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/btas_alu.sv
module btas_alu (
    input  logic [btas_pkg::ADDR_W-1:0] i_a,
    input  logic [btas_pkg::ADDR_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [btas_pkg::ADDR_W-1:0] o_sum
);
    import btas_pkg::*;

    // Shared 32-bit adder/subtractor, wraps modulo 2^32
    always_comb begin
        if (i_sub) begin
            o_sum = i_a - i_b;
        end else begin
            o_sum = i_a + i_b;
        end
    end

endmodule
